// File: rtl/pec_pkg.sv
package pec_pkg;

    localparam int FixW = 24;

    typedef logic signed [FixW-1:0] fix_t;

    localparam fix_t FIX_MAX = 24'sh7FFFFF;
    localparam fix_t FIX_MIN = 24'sh800000;

    // register indexes on the configuration channel
    localparam logic [2:0] REG_GRAVITY    = 3'd0;
    localparam logic [2:0] REG_TIME_SCALE = 3'd1;
    localparam logic [2:0] REG_BOX_LEFT   = 3'd2;
    localparam logic [2:0] REG_BOX_TOP    = 3'd3;
    localparam logic [2:0] REG_BOX_WIDTH  = 3'd4;
    localparam logic [2:0] REG_BOX_HEIGHT = 3'd5;

    // live configuration, walls already resolved
    typedef struct packed {
        fix_t        grav;
        logic [15:0] tscale;
        fix_t        left;
        fix_t        top;
        fix_t        floor_lv;
        fix_t        right;
    } cfg_t;

    // one body as it moves down the pipeline
    typedef struct packed {
        logic       valid;
        logic       fixed;
        logic       last;
        fix_t       px;
        fix_t       py;
        fix_t       vx;
        fix_t       vy;
        logic [8:0] bf;
    } body_t;

    function automatic fix_t sat_fix(input logic signed [39:0] v);
        fix_t r;
        if (v > 40'(FIX_MAX))
            r = FIX_MAX;
        else if (v < 40'(FIX_MIN))
            r = FIX_MIN;
        else
            r = v[FixW-1:0];
        return r;
    endfunction

endpackage

// File: rtl/pec_cfg.sv
module pec_cfg
    import pec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [23:0] wr_data,
    output cfg_t        cfg
);

    fix_t        grav_reg;
    logic [15:0] tscale_reg;
    fix_t        left_reg;
    fix_t        top_reg;
    logic [22:0] width_reg;
    logic [22:0] height_reg;
    fix_t        floor_reg;
    fix_t        right_reg;

    fix_t floor_next;
    fix_t right_next;

    // walls are registered sums of the written box values; items take longer to reach them
    assign floor_next = sat_fix(40'(top_reg) + 40'($signed({1'b0, height_reg})));
    assign right_next = sat_fix(40'(left_reg) + 40'($signed({1'b0, width_reg})));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg   <= '0;
            tscale_reg <= 16'd256;
            left_reg   <= 24'sd10240;
            top_reg    <= 24'sd10240;
            width_reg  <= '0;
            height_reg <= '0;
            floor_reg  <= 24'sd10240;
            right_reg  <= 24'sd10240;
        end
        else
        begin
            floor_reg <= floor_next;
            right_reg <= right_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_GRAVITY:    grav_reg   <= wr_data;
                    REG_TIME_SCALE: tscale_reg <= wr_data[15:0];
                    REG_BOX_LEFT:   left_reg   <= wr_data;
                    REG_BOX_TOP:    top_reg    <= wr_data;
                    REG_BOX_WIDTH:  width_reg  <= wr_data[22:0];
                    REG_BOX_HEIGHT: height_reg <= wr_data[22:0];
                    default:        ;
                endcase
            end
        end
    end

    assign cfg.grav     = grav_reg;
    assign cfg.tscale   = tscale_reg;
    assign cfg.left     = left_reg;
    assign cfg.top      = top_reg;
    assign cfg.floor_lv = floor_reg;
    assign cfg.right    = right_reg;

endmodule

// File: rtl/pec_kin.sv
module pec_kin
    import pec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  cfg_t        cfg,
    input  body_t       body_in,
    input  logic [15:0] dt,
    output body_t       body_out
);

    // S1: effective step
    body_t       b1_reg;
    logic [23:0] step1_reg;
    logic [31:0] step_prod;

    // S2: gravity and x velocity products
    body_t              b2_reg;
    logic [23:0]        step2_reg;
    logic signed [48:0] gp_reg;
    logic signed [48:0] vxp_reg;
    logic signed [48:0] gp_next;
    logic signed [48:0] vxp_next;

    // S3: vy gains gravity, x moves
    body_t       b3_reg;
    logic [23:0] step3_reg;
    body_t       b3_next;

    // S4: y displacement product
    body_t              b4_reg;
    logic signed [48:0] vyp_reg;
    logic signed [48:0] vyp_next;

    // S5: y moves
    body_t b5_reg;
    body_t b5_next;

    assign step_prod = dt * cfg.tscale;
    assign gp_next   = 49'(cfg.grav) * 49'($signed({1'b0, step1_reg}));
    assign vxp_next  = 49'(b1_reg.vx) * 49'($signed({1'b0, step1_reg}));
    assign vyp_next  = 49'(b3_reg.vy) * 49'($signed({1'b0, step3_reg}));

    always_comb
    begin
        b3_next    = b2_reg;
        b3_next.vy = sat_fix(40'(b2_reg.vy) + 40'($signed(gp_reg[48:16])));
        b3_next.px = sat_fix(40'(b2_reg.px) + 40'($signed(vxp_reg[48:16])));
        b5_next    = b4_reg;
        b5_next.py = sat_fix(40'(b4_reg.py) + 40'($signed(vyp_reg[48:16])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= '0;
            b2_reg <= '0;
            b3_reg <= '0;
            b4_reg <= '0;
            b5_reg <= '0;
        end
        else if (en)
        begin
            b1_reg <= body_in;
            b2_reg <= b1_reg;
            b3_reg <= b3_next;
            b4_reg <= b3_reg;
            b5_reg <= b5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a static body moves with a zero step, so it comes out unchanged
            step1_reg <= body_in.fixed ? '0 : step_prod[31:8];
            step2_reg <= step1_reg;
            gp_reg    <= gp_next;
            vxp_reg   <= vxp_next;
            step3_reg <= step2_reg;
            vyp_reg   <= vyp_next;
        end
    end

    assign body_out = b5_reg;

endmodule

// File: rtl/pec_wall.sv
module pec_wall
    import pec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  cfg_t       cfg,
    input  body_t      body_in,
    output logic       out_valid,
    output logic       out_last,
    output fix_t       out_px,
    output fix_t       out_py,
    output fix_t       out_vx,
    output fix_t       out_vy,
    output logic [3:0] out_hits
);

    // S6: compare, clamp, elasticity products
    logic               v6_reg;
    logic               last6_reg;
    fix_t               px6_reg;
    fix_t               py6_reg;
    fix_t               vx6_reg;
    fix_t               vy6_reg;
    logic [3:0]         hits6_reg;
    logic signed [33:0] ex_reg;
    logic signed [33:0] ey_reg;

    logic       hit_floor;
    logic       hit_ceil;
    logic       hit_left;
    logic       hit_right;
    fix_t       px6_next;
    fix_t       py6_next;

    // S7: output register
    logic       v7_reg;
    logic       last7_reg;
    fix_t       px7_reg;
    fix_t       py7_reg;
    fix_t       vx7_reg;
    fix_t       vy7_reg;
    logic [3:0] hits7_reg;
    fix_t       bx;
    fix_t       by;

    // floor >= top and right >= left, so at most one wall per axis fires
    always_comb
    begin
        hit_floor = !body_in.fixed && (body_in.py > cfg.floor_lv);
        hit_ceil  = !body_in.fixed && !hit_floor && (body_in.py < cfg.top);
        hit_left  = !body_in.fixed && (body_in.px < cfg.left);
        hit_right = !body_in.fixed && !hit_left && (body_in.px > cfg.right);
        py6_next  = hit_floor ? cfg.floor_lv : (hit_ceil ? cfg.top : body_in.py);
        px6_next  = hit_left ? cfg.left : (hit_right ? cfg.right : body_in.px);
        // reflected velocity: floor of product / 256, negated, saturated
        bx = sat_fix(-40'($signed(ex_reg[33:8])));
        by = sat_fix(-40'($signed(ey_reg[33:8])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= body_in.valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last6_reg <= body_in.last;
            px6_reg   <= px6_next;
            py6_reg   <= py6_next;
            vx6_reg   <= body_in.vx;
            vy6_reg   <= body_in.vy;
            hits6_reg <= {hit_right, hit_left, hit_ceil, hit_floor};
            ex_reg    <= 34'(body_in.vx) * 34'($signed({1'b0, body_in.bf}));
            ey_reg    <= 34'(body_in.vy) * 34'($signed({1'b0, body_in.bf}));

            last7_reg <= last6_reg;
            px7_reg   <= px6_reg;
            py7_reg   <= py6_reg;
            vx7_reg   <= (hits6_reg[2] || hits6_reg[3]) ? bx : vx6_reg;
            vy7_reg   <= (hits6_reg[0] || hits6_reg[1]) ? by : vy6_reg;
            hits7_reg <= hits6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_last  = last7_reg;
    assign out_px    = px7_reg;
    assign out_py    = py7_reg;
    assign out_vx    = vx7_reg;
    assign out_vy    = vy7_reg;
    assign out_hits  = hits7_reg;

endmodule

// File: rtl/particle_euler_step_with_wall_bounce_core.sv
// Particle step core: advances one body per request by one semi-implicit
// Euler step and bounces it off a box. vy gains gravity*step first, then
// x and y move by velocity*step (step = dt*time_scale, Q8.16), then the
// position is checked against floor, ceiling, left and right wall; a hit
// clamps to the wall and reflects the normal velocity scaled by
// bounce_factor. Static bodies (tuser) pass unchanged with no hits.
// Throughput is one body per cycle while the output is not stalled; each
// request passes through the 7-stage pipeline (step multiply,
// velocity products, x/vy sums, y product, y sum, wall compare with
// elasticity products, bounce select). The whole pipeline advances when
// the output register is empty or being taken, so a stall holds every
// stage. Configuration writes are always accepted (cfg_ready is tied
// high) and should be issued only while no body is in flight.
module particle_euler_step_with_wall_bounce_core
    import pec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,

    // body requests
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] step_dt, [39:16] pos_x, [63:40] pos_y, [87:64] vel_x,
    // [111:88] vel_y, [120:112] bounce_factor, [127:121] zero
    input  logic [127:0] s_tdata,
    // [0] fixed_body
    input  logic         s_tuser,
    // last_body
    input  logic         s_tlast,

    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] new_pos_x, [47:24] new_pos_y, [71:48] new_vel_x,
    // [95:72] new_vel_y, [99:96] hit_walls, [103:100] zero
    output logic [103:0] m_tdata,
    // last_out
    output logic         m_tlast
);

    cfg_t  cfg;
    body_t body_in;
    body_t body_mid;
    logic  en;

    fix_t       out_px;
    fix_t       out_py;
    fix_t       out_vx;
    fix_t       out_vy;
    logic [3:0] out_hits;

    // pipeline moves whenever the output slot is free or draining
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign body_in.valid = s_tvalid;
    assign body_in.fixed = s_tuser;
    assign body_in.last  = s_tlast;
    assign body_in.px    = s_tdata[39:16];
    assign body_in.py    = s_tdata[63:40];
    assign body_in.vx    = s_tdata[87:64];
    assign body_in.vy    = s_tdata[111:88];
    assign body_in.bf    = s_tdata[120:112];

    pec_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // stages 1..5: step, gravity, motion
    pec_kin u_kin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg),
        .body_in  (body_in),
        .dt       (s_tdata[15:0]),
        .body_out (body_mid)
    );

    // stages 6..7: walls and bounce, stage 7 is the output register
    pec_wall u_wall (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .body_in   (body_mid),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_px    (out_px),
        .out_py    (out_py),
        .out_vx    (out_vx),
        .out_vy    (out_vy),
        .out_hits  (out_hits)
    );

    assign m_tdata = {4'b0000, out_hits, out_vy, out_vx, out_py, out_px};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pec_pkg::*;

    // one body request as driven on the slave stream
    typedef struct {
        logic [15:0] dt;
        fix_t        px;
        fix_t        py;
        fix_t        vx;
        fix_t        vy;
        logic [8:0]  bf;
        logic        fixed;
        logic        last;
    } body_req_t;

    // one stepped body as seen on the master stream
    typedef struct {
        fix_t       px;
        fix_t       py;
        fix_t       vx;
        fix_t       vy;
        logic [3:0] hits;
        logic       last;
    } body_result_t;

    // Keeps a copy of the box and gravity registers, steps every accepted
    // body itself and holds the stepped bodies until the block returns them.
    class bounce_scoreboard;
        fix_t         grav   = '0;
        logic [15:0]  tscale = 16'd256;
        fix_t         left   = 24'sd10240;
        fix_t         top    = 24'sd10240;
        logic [22:0]  width  = '0;
        logic [22:0]  height = '0;
        body_result_t stepped_q[$];
        int unsigned  failures = 0;

        static function longint saturate(longint v);
            if (v > longint'(FIX_MAX))
                return longint'(FIX_MAX);
            if (v < longint'(FIX_MIN))
                return longint'(FIX_MIN);
            return v;
        endfunction

        // velocity scaled by elasticity (floor rounding), then reflected
        static function longint rebound(longint v, longint e);
            return saturate(-((v * e) >>> 8));
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] d);
            case (idx)
                REG_GRAVITY:    grav   = d;
                REG_TIME_SCALE: tscale = d[15:0];
                REG_BOX_LEFT:   left   = d;
                REG_BOX_TOP:    top    = d;
                REG_BOX_WIDTH:  width  = d[22:0];
                REG_BOX_HEIGHT: height = d[22:0];
                default: ;  // unknown index: dropped
            endcase
        endfunction

        // walls as the block compares them; floor and right wall saturate
        function void walls(output longint l, output longint r,
                            output longint t, output longint f);
            l = longint'(left);
            t = longint'(top);
            r = saturate(l + longint'(width));
            f = saturate(t + longint'(height));
        endfunction

        function void note_request(body_req_t b);
            body_result_t res;
            longint step, px, py, vx, vy, e, l, r, t, f;
            px = longint'(b.px);
            py = longint'(b.py);
            vx = longint'(b.vx);
            vy = longint'(b.vy);
            e  = longint'(b.bf);
            res.hits = '0;
            res.last = b.last;
            if (!b.fixed) begin
                walls(l, r, t, f);
                // Q0.16 * Q8.8 -> Q8.16
                step = (longint'(b.dt) * longint'(tscale)) >>> 8;
                // semi-implicit: y moves with the velocity after gravity
                vy = saturate(vy + ((longint'(grav) * step) >>> 16));
                px = saturate(px + ((vx * step) >>> 16));
                py = saturate(py + ((vy * step) >>> 16));
                if (py > f) begin
                    py = f;
                    vy = rebound(vy, e);
                    res.hits[0] = 1'b1;
                end
                if (py < t) begin
                    py = t;
                    vy = rebound(vy, e);
                    res.hits[1] = 1'b1;
                end
                if (px < l) begin
                    px = l;
                    vx = rebound(vx, e);
                    res.hits[2] = 1'b1;
                end
                if (px > r) begin
                    px = r;
                    vx = rebound(vx, e);
                    res.hits[3] = 1'b1;
                end
            end
            res.px = px[23:0];
            res.py = py[23:0];
            res.vx = vx[23:0];
            res.vy = vy[23:0];
            stepped_q.push_back(res);
        endfunction

        function void mismatch(string field, longint want_v, longint got_v);
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            failures++;
        endfunction

        function void check_result(body_result_t got);
            body_result_t want;
            if (stepped_q.size() == 0) begin
                $error("result with no request outstanding: pos %0d,%0d",
                       got.px, got.py);
                failures++;
                return;
            end
            want = stepped_q.pop_front();
            if (got.px !== want.px)
                mismatch("new_pos_x", longint'(want.px), longint'(got.px));
            if (got.py !== want.py)
                mismatch("new_pos_y", longint'(want.py), longint'(got.py));
            if (got.vx !== want.vx)
                mismatch("new_vel_x", longint'(want.vx), longint'(got.vx));
            if (got.vy !== want.vy)
                mismatch("new_vel_y", longint'(want.vy), longint'(got.vy));
            if (got.hits !== want.hits)
                mismatch("hit_walls", longint'(want.hits), longint'(got.hits));
            if (got.last !== want.last)
                mismatch("last_out", longint'(want.last), longint'(got.last));
        endfunction

        function int pending();
            return stepped_q.size();
        endfunction
    endclass

    localparam int RandPhases    = 8;
    localparam int PhaseBodies   = 131;
    localparam int PressurePhase = 4;
    localparam int DrainCycles   = 12;   // pipeline is 7 deep, output reg included

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [127:0] s_tdata;  // dt, pos_x, pos_y, vel_x, vel_y, bounce_factor, zero
    logic s_tuser;          // fixed_body
    logic s_tlast;          // last_body
    logic m_tvalid;
    logic m_tready;
    logic [103:0] m_tdata;  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit_walls, zero
    logic m_tlast;          // last_out

    bounce_scoreboard sb = new;

    int send_idle = 0;      // percent of cycles the sender holds back
    int recv_stall = 0;     // percent of cycles the receiver holds back
    int holdoff_cycles = 0; // one-shot long receiver stall

    particle_euler_step_with_wall_bounce_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random back-pressure, plus the long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (holdoff_cycles) @(posedge clk);
                holdoff_cycles = 0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        body_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.px   = m_tdata[23:0];
            got.py   = m_tdata[47:24];
            got.vx   = m_tdata[71:48];
            got.vy   = m_tdata[95:72];
            got.hits = m_tdata[99:96];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic body_req_t mk(logic [15:0] dt, fix_t px, fix_t py, fix_t vx,
                                     fix_t vy, logic [8:0] bf, logic fixed, logic last);
        body_req_t b;
        b.dt = dt;
        b.px = px;
        b.py = py;
        b.vx = vx;
        b.vy = vy;
        b.bf = bf;
        b.fixed = fixed;
        b.last = last;
        return b;
    endfunction

    function automatic fix_t extreme_value();
        case ($urandom_range(3))
            0: return FIX_MAX;
            1: return FIX_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // mostly around the wall pair, so crossings are common
    function automatic fix_t random_coord(longint lo, longint hi);
        longint margin, v;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return extreme_value();
            default:
            begin
                margin = (hi - lo) / 4 + 4096;
                v = lo - margin + longint'($urandom_range(32'(hi - lo + 2 * margin)));
                return 24'(bounce_scoreboard::saturate(v));
            end
        endcase
    endfunction

    function automatic fix_t random_speed();
        longint mag;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return extreme_value();
            default:
            begin
                mag = 64'd1 << $urandom_range(4, 22);
                return 24'(longint'($urandom_range(32'(2 * mag))) - mag);
            end
        endcase
    endfunction

    function automatic body_req_t random_body();
        body_req_t b;
        longint l, r, t, f;
        sb.walls(l, r, t, f);
        case ($urandom_range(9))
            0: b.dt = '0;
            1: b.dt = '1;
            default: b.dt = 16'($urandom);
        endcase
        b.px = random_coord(l, r);
        b.py = random_coord(t, f);
        b.vx = random_speed();
        b.vy = random_speed();
        // elasticity above 1.0 now and then
        if ($urandom_range(9) == 0)
            b.bf = 9'($urandom_range(257, 511));
        else
            b.bf = 9'($urandom_range(256));
        b.fixed = ($urandom_range(9) == 0);
        b.last = ($urandom_range(7) == 0);
        return b;
    endfunction

    task automatic send_body(body_req_t b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b.bf, b.vy, b.vx, b.py, b.px, b.dt};
        s_tuser  <= b.fixed;
        s_tlast  <= b.last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(b);
    endtask

    // stop sending and let the pipeline empty completely
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    // writes all six registers plus the two unused indexes
    task automatic write_box(logic [23:0] g, logic [23:0] ts, logic [23:0] l,
                             logic [23:0] t, logic [23:0] w, logic [23:0] h);
        logic [23:0] vals [8];
        vals[REG_GRAVITY]    = g;
        vals[REG_TIME_SCALE] = ts;
        vals[REG_BOX_LEFT]   = l;
        vals[REG_BOX_TOP]    = t;
        vals[REG_BOX_WIDTH]  = w;
        vals[REG_BOX_HEIGHT] = h;
        vals[6] = 24'($urandom);
        vals[7] = 24'($urandom);
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), vals[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int k);
        case (k)
            // 640 x 480 box at the origin, gravity 9.8, real time
            0: write_box(24'd2509, 24'd256, 24'd0, 24'd0, 24'd163840, 24'd122880);
            // maximum gravity and box size: huge steps, left/top at the minimum, floor/right at -1
            1: write_box(24'h7FFFFF, 24'hFFFF, 24'h800000, 24'h800000,
                         24'h7FFFFF, 24'h7FFFFF);
            // frozen time, box pushed past the range (walls saturate)
            2: write_box(24'h800000, 24'h0, 24'h7FFFFF, 24'h7FFFFF,
                         24'h7FFFFF, 24'h7FFFFF);
            // small box, gravity pulling up, 1.5x time
            3: write_box(-24'sd1000, 24'd384, -24'sd5120, 24'sd2560, 24'd1024, 24'd768);
            default: write_box(24'($urandom), 24'($urandom_range(1023)), 24'($urandom),
                               24'($urandom), 24'($urandom), 24'($urandom));
        endcase
    endtask

    initial
    begin
        int settings [RandPhases];
        settings = '{0, 1, 0, 2, 4, 3, 4, 0};

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: the box is a single point at (40, 40)
        send_body(mk(16'h8000, 24'sd10240, 24'sd10240, 24'sd256, 24'sd256, 9'd256,
                     1'b0, 1'b0));
        send_body(mk(16'hFFFF, 24'sd0, 24'sd20000, 24'sd5000, -24'sd5000, 9'd100,
                     1'b0, 1'b1));
        send_body(mk(16'h0000, FIX_MAX, FIX_MIN, 24'sd0, 24'sd0, 9'd0, 1'b0, 1'b0));
        wait_quiet();
        apply_setting(0);

        // directed bodies in the 640 x 480 box
        // static body with extreme fields passes untouched
        send_body(mk(16'hFFFF, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MAX, 9'h1FF, 1'b1, 1'b1));
        send_body(mk(16'h1234, 24'sd1000, 24'sd2000, 24'sd3000, 24'sd4000, 9'd100,
                     1'b1, 1'b0));
        // zero step, at rest, all-zero body on the top-left corner
        send_body(mk(16'h0000, 24'sd51200, 24'sd51200, 24'sd0, 24'sd0, 9'd256,
                     1'b0, 1'b0));
        send_body(mk(16'h0000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 9'd0, 1'b0, 1'b0));
        // free flight inside
        send_body(mk(16'h4000, 24'sd51200, 24'sd51200, 24'sd2560, -24'sd1792, 9'd200,
                     1'b0, 1'b0));
        // each wall alone
        send_body(mk(16'h8000, 24'sd51200, 24'sd122000, 24'sd0, 24'sd25600, 9'd256,
                     1'b0, 1'b0));
        send_body(mk(16'h8000, 24'sd51200, 24'sd1000, 24'sd0, -24'sd25600, 9'd128,
                     1'b0, 1'b0));
        send_body(mk(16'hFFFF, 24'sd500, 24'sd51200, -24'sd12800, 24'sd0, 9'd256,
                     1'b0, 1'b0));
        send_body(mk(16'hFFFF, 24'sd163000, 24'sd51200, 24'sd12800, 24'sd0, 9'd192,
                     1'b0, 1'b0));
        // corners
        send_body(mk(16'hFFFF, 24'sd163000, 24'sd122000, 24'sd12800, 24'sd12800,
                     9'd256, 1'b0, 1'b1));
        send_body(mk(16'hFFFF, 24'sd500, 24'sd500, -24'sd12800, -24'sd12800, 9'd64,
                     1'b0, 1'b0));
        // dead stop at the wall
        send_body(mk(16'hFFFF, 24'sd500, 24'sd51200, -24'sd12800, 24'sd0, 9'd0,
                     1'b0, 1'b0));
        // elasticity above one saturates the rebound
        send_body(mk(16'hFFFF, 24'sd163000, 24'sd51200, 24'sh7F0000, 24'sd0, 9'd511,
                     1'b0, 1'b0));
        // most negative velocity reflected: negation saturates
        send_body(mk(16'hFFFF, 24'sd0, 24'sd51200, FIX_MIN, 24'sd0, 9'd256, 1'b0, 1'b0));
        // position and velocity sums saturate
        send_body(mk(16'hFFFF, FIX_MAX, 24'sd51200, FIX_MAX, 24'sd0, 9'd256, 1'b0, 1'b0));
        send_body(mk(16'hFFFF, 24'sd51200, 24'sd51200, 24'sd0, FIX_MAX, 9'd256,
                     1'b0, 1'b0));
        send_body(mk(16'hFFFF, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN, 9'd256, 1'b0, 1'b0));
        send_body(mk(16'h0100, 24'sd51200, 24'sd51200, -24'sd3000, 24'sd3000, 9'd256,
                     1'b0, 1'b1));

        // random phases: config changes only with the pipeline empty
        for (int p = 0; p < RandPhases; p++)
        begin
            wait_quiet();
            apply_setting(settings[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 54; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 54; end
                default: begin send_idle = 25; recv_stall = 25; end
            endcase
            for (int n = 0; n < PhaseBodies; n++)
            begin
                // long output stall while requests keep coming: pipeline backs up
                if (p == PressurePhase && n == 20)
                    holdoff_cycles = 60;
                // sender pauses until everything has come back
                if (p == PressurePhase && n == 90)
                    wait_quiet();
                send_body(random_body());
            end
        end

        wait_quiet();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/pec_pkg.sv
rtl/pec_cfg.sv
rtl/pec_kin.sv
rtl/pec_wall.sv
rtl/particle_euler_step_with_wall_bounce_core.sv
test/testbench.sv
